### design/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the regulator checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/pireg_pkg.sv
// ---------------------------------------------------------------------------
// pireg_pkg
// Types, constants and register indexes shared by the PI regulator modules.
// ---------------------------------------------------------------------------
package pireg_pkg;

	// Channel count and integral preload scale
	localparam int NUM_CHANNELS  = 3;
	localparam int PRELOAD_SCALE = 350;

	// Field widths
	localparam int CHAN_W  = 2;
	localparam int TEMP_W  = 16;
	localparam int GAIN_W  = 8;
	localparam int TDIV_W  = 10;
	localparam int INTEG_W = 16;
	localparam int DRIVE_W = 10;
	localparam int ERR_W   = TEMP_W + 1;
	localparam int QUO_W   = INTEG_W + 1;
	localparam int PROD_W  = 28;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_DIV    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_UPPER  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_LOWER  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_HIGH   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_ON     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LOW    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_OFF    = 3'd7;

	// Divider runs one quotient bit per cycle
	localparam int DIV_STEPS = INTEG_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

	typedef struct packed {
		logic        [GAIN_W-1:0]  prop_gain;
		logic        [TDIV_W-1:0]  integral_divisor;
		logic signed [INTEG_W-1:0] integral_upper;
		logic signed [INTEG_W-1:0] integral_lower;
		logic        [DRIVE_W-1:0] drive_high_limit;
		logic        [DRIVE_W-1:0] drive_full_on;
		logic        [DRIVE_W-1:0] drive_low_limit;
		logic        [DRIVE_W-1:0] drive_full_off;
	} cfg_t;

	typedef struct packed {
		logic                      start;
		logic signed [INTEG_W-1:0] dividend;
		logic        [TDIV_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic                    done;
		logic signed [QUO_W-1:0] quotient;
	} div_rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SUM,
		S_CLAMP,
		S_PROD,
		S_DIV,
		S_LIM
	} state_t;

endpackage

### design/multichannel_pi_temperature_regulator.sv
// ---------------------------------------------------------------------------
// multichannel_pi_temperature_regulator
// Multichannel PI regulator with integral preload, integral clamping and
// drive limiting; integral term divided by a shared iterative divider.
// ---------------------------------------------------------------------------
//  channel   handshake             payload
//  in        in_valid / in_ready   chan, measured_temp, target_temp
//  out       out_valid / out_ready drive_level
//  cfg       cfg_we                cfg_idx, cfg_wdata
//
// Each word passes through four sequencer steps (sum, clamp, product, limit)
// and, between product and limit, the bit-serial divider (16 quotient bits and
// a completion flag). The next word can be accepted only after the result is
// loaded, so the block does not take a new word while one is in flight.
// If the output register still holds an untaken result, the load waits for it.
// Reset is asynchronous and clears the integrals and the registers to defaults.
// ---------------------------------------------------------------------------
module multichannel_pi_temperature_regulator (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic        [pireg_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic        [pireg_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic        [pireg_pkg::CHAN_W-1:0]  chan,
	input  logic signed [pireg_pkg::TEMP_W-1:0]  measured_temp,
	input  logic signed [pireg_pkg::TEMP_W-1:0]  target_temp,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic        [pireg_pkg::DRIVE_W-1:0] drive_level
);

	pireg_pkg::cfg_t     cfg;
	pireg_pkg::div_req_t div_req;
	pireg_pkg::div_rsp_t div_rsp;

	// Configuration registers
	pireg_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Sequencer and datapath
	pireg_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.chan          (chan),
		.measured_temp (measured_temp),
		.target_temp   (target_temp),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.drive_level   (drive_level),
		.div_req       (div_req),
		.div_rsp       (div_rsp)
	);

	// Shared divider
	pireg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

endmodule

### design/pireg_cfg.sv
// ---------------------------------------------------------------------------
// pireg_cfg
// Configuration register bank, written through a plain indexed write port.
// ---------------------------------------------------------------------------
module pireg_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pireg_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [pireg_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	output pireg_pkg::cfg_t                     cfg
);

	pireg_pkg::cfg_t cfg_q;

	// Update the addressed register; every index is a register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain        <= 8'd10;
			cfg_q.integral_divisor <= 10'd10;
			cfg_q.integral_upper   <= 16'sh7FFF;
			cfg_q.integral_lower   <= 16'sh8000;
			cfg_q.drive_high_limit <= 10'd1000;
			cfg_q.drive_full_on    <= 10'd1000;
			cfg_q.drive_low_limit  <= 10'd0;
			cfg_q.drive_full_off   <= 10'd0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				pireg_pkg::REG_PROP_GAIN:   cfg_q.prop_gain <= cfg_wdata[7:0];
				pireg_pkg::REG_INTEG_DIV:   cfg_q.integral_divisor <= cfg_wdata[9:0];
				pireg_pkg::REG_INTEG_UPPER: cfg_q.integral_upper <= cfg_wdata;
				pireg_pkg::REG_INTEG_LOWER: cfg_q.integral_lower <= cfg_wdata;
				pireg_pkg::REG_DRIVE_HIGH:  cfg_q.drive_high_limit <= cfg_wdata[9:0];
				pireg_pkg::REG_DRIVE_ON:    cfg_q.drive_full_on <= cfg_wdata[9:0];
				pireg_pkg::REG_DRIVE_LOW:   cfg_q.drive_low_limit <= cfg_wdata[9:0];
				pireg_pkg::REG_DRIVE_OFF:   cfg_q.drive_full_off <= cfg_wdata[9:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### design/pireg_div.sv
// ---------------------------------------------------------------------------
// pireg_div
// Shared restoring divider: signed dividend by positive divisor, truncated
// toward zero, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module pireg_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pireg_pkg::div_req_t  req,
	output pireg_pkg::div_rsp_t  rsp
);

	logic                                busy_q;
	logic                                done_q;
	logic [pireg_pkg::DIV_CNT_W-1:0]     cnt_q;
	logic [pireg_pkg::INTEG_W-1:0]       mag_q;
	logic [pireg_pkg::TDIV_W-1:0]        rem_q;
	logic [pireg_pkg::TDIV_W-1:0]        dsr_q;
	logic                                neg_q;

	logic [pireg_pkg::TDIV_W:0]          rem_sh;
	logic [pireg_pkg::TDIV_W:0]          rem_sub;
	logic                                q_bit;
	logic [pireg_pkg::INTEG_W-1:0]       abs_in;
	logic [pireg_pkg::QUO_W-1:0]         quo_mag;

	// Magnitude of the dividend; the most negative value maps to its unsigned form
	assign abs_in = req.dividend[pireg_pkg::INTEG_W-1] ?
		(~req.dividend + 1'b1) : req.dividend;

	// One trial subtraction per step
	always_comb begin
		rem_sh  = {rem_q, mag_q[pireg_pkg::INTEG_W-1]};
		rem_sub = rem_sh - {1'b0, dsr_q};
		q_bit   = (rem_sh >= {1'b0, dsr_q});
	end

	// Control: start, count down, flag completion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= pireg_pkg::DIV_CNT_W'(pireg_pkg::DIV_STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == pireg_pkg::DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Datapath: shift dividend bits out, quotient bits in
	always_ff @(posedge clk) begin
		if (req.start) begin
			mag_q <= abs_in;
			rem_q <= '0;
			dsr_q <= req.divisor;
			neg_q <= req.dividend[pireg_pkg::INTEG_W-1];
		end else if (busy_q) begin
			rem_q <= q_bit ? rem_sub[pireg_pkg::TDIV_W-1:0] : rem_sh[pireg_pkg::TDIV_W-1:0];
			mag_q <= {mag_q[pireg_pkg::INTEG_W-2:0], q_bit};
		end
	end

	// Restore the sign of the quotient
	assign quo_mag      = {1'b0, mag_q};
	assign rsp.done     = done_q;
	assign rsp.quotient = neg_q ? $signed(~quo_mag + 1'b1) : $signed(quo_mag);

endmodule

### design/pireg_ctrl.sv
// ---------------------------------------------------------------------------
// pireg_ctrl
// Sequencer, integral store, shared multiplier and output word register.
// ---------------------------------------------------------------------------
module pireg_ctrl (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  pireg_pkg::cfg_t                      cfg,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic        [pireg_pkg::CHAN_W-1:0]  chan,
	input  logic signed [pireg_pkg::TEMP_W-1:0]  measured_temp,
	input  logic signed [pireg_pkg::TEMP_W-1:0]  target_temp,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic        [pireg_pkg::DRIVE_W-1:0] drive_level,
	output pireg_pkg::div_req_t                  div_req,
	input  pireg_pkg::div_rsp_t                  div_rsp
);

	localparam int IW = pireg_pkg::INTEG_W;
	localparam int PW = pireg_pkg::PROD_W;

	pireg_pkg::state_t state_q, state_d;

	logic signed [IW-1:0]                  store_q [pireg_pkg::NUM_CHANNELS];
	logic        [pireg_pkg::CHAN_W-1:0]   ch_q;
	logic                                  ch_ok_q;
	logic signed [pireg_pkg::ERR_W-1:0]    err_q;
	logic        [pireg_pkg::TDIV_W-1:0]   divn_q;
	logic signed [IW+1:0]                  integ_q;
	logic signed [IW-1:0]                  integ_new_q;
	logic signed [PW-1:0]                  prod_q;
	logic signed [PW-1:0]                  drv_q;
	logic                                  out_valid_q;
	logic        [pireg_pkg::DRIVE_W-1:0]  drive_q;

	logic                                  accept;
	logic                                  store_we;
	logic                                  mul_gain;
	logic                                  out_load;
	logic signed [IW-1:0]                  store_rd;
	logic signed [pireg_pkg::ERR_W-1:0]    mul_a;
	logic        [pireg_pkg::TDIV_W-1:0]   mul_b;
	logic signed [PW-1:0]                  mul_res;
	logic signed [PW-1:0]                  clamp_v;
	logic signed [PW-1:0]                  upper_ext;
	logic signed [PW-1:0]                  lower_ext;
	logic signed [PW-1:0]                  drv_sum;
	logic signed [PW-1:0]                  lim_v;
	logic signed [PW-1:0]                  hi_ext;
	logic signed [PW-1:0]                  lo_ext;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == pireg_pkg::S_IDLE);

	// Read the channel's integral; an unknown channel reads zero
	always_comb begin
		store_rd = '0;
		for (int i = 0; i < pireg_pkg::NUM_CHANNELS; i++) begin
			if (ch_ok_q && (32'(ch_q) == i)) begin
				store_rd = store_q[i];
			end
		end
	end

	// Shared multiplier: preload floor first, then proportional term
	assign mul_a   = mul_gain ? err_q : pireg_pkg::ERR_W'(pireg_pkg::PRELOAD_SCALE);
	assign mul_b   = mul_gain ? {2'b00, cfg.prop_gain} : divn_q;
	assign mul_res = PW'(mul_a) * PW'($signed({1'b0, mul_b}));

	// Preload floor, then upper clamp, then lower clamp
	always_comb begin
		upper_ext = PW'(cfg.integral_upper);
		lower_ext = PW'(cfg.integral_lower);
		clamp_v   = PW'(integ_q);
		if ((err_q > 0) && (clamp_v < prod_q)) begin
			clamp_v = prod_q;
		end
		if (clamp_v > upper_ext) begin
			clamp_v = upper_ext;
		end
		if (clamp_v < lower_ext) begin
			clamp_v = lower_ext;
		end
	end

	// Add the integral term, then apply the drive limits in order
	always_comb begin
		drv_sum = prod_q + PW'(div_rsp.quotient);
		hi_ext  = $signed({{(PW-pireg_pkg::DRIVE_W){1'b0}}, cfg.drive_high_limit});
		lo_ext  = $signed({{(PW-pireg_pkg::DRIVE_W){1'b0}}, cfg.drive_low_limit});
		lim_v   = drv_q;
		if (lim_v > hi_ext) begin
			lim_v = $signed({{(PW-pireg_pkg::DRIVE_W){1'b0}}, cfg.drive_full_on});
		end
		if (lim_v < lo_ext) begin
			lim_v = $signed({{(PW-pireg_pkg::DRIVE_W){1'b0}}, cfg.drive_full_off});
		end
	end

	// Next state and sequencer outputs
	always_comb begin
		state_d           = state_q;
		store_we          = 1'b0;
		mul_gain          = 1'b0;
		out_load          = 1'b0;
		div_req.start     = 1'b0;
		div_req.dividend  = integ_new_q;
		div_req.divisor   = divn_q;
		unique case (state_q)
			pireg_pkg::S_IDLE: begin
				if (accept) begin
					state_d = pireg_pkg::S_SUM;
				end
			end
			pireg_pkg::S_SUM: begin
				state_d = pireg_pkg::S_CLAMP;
			end
			pireg_pkg::S_CLAMP: begin
				store_we = ch_ok_q;
				state_d  = pireg_pkg::S_PROD;
			end
			pireg_pkg::S_PROD: begin
				mul_gain      = 1'b1;
				div_req.start = 1'b1;
				state_d       = pireg_pkg::S_DIV;
			end
			pireg_pkg::S_DIV: begin
				if (div_rsp.done) begin
					state_d = pireg_pkg::S_LIM;
				end
			end
			pireg_pkg::S_LIM: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = pireg_pkg::S_IDLE;
				end
			end
			default: state_d = pireg_pkg::S_IDLE;
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pireg_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Integral store, cleared on reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pireg_pkg::NUM_CHANNELS; i++) begin
				store_q[i] <= '0;
			end
		end else if (store_we) begin
			for (int i = 0; i < pireg_pkg::NUM_CHANNELS; i++) begin
				if (32'(ch_q) == i) begin
					store_q[i] <= clamp_v[IW-1:0];
				end
			end
		end
	end

	// Working registers of the current word
	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q    <= chan;
			ch_ok_q <= (32'(chan) < pireg_pkg::NUM_CHANNELS);
			err_q   <= {measured_temp[pireg_pkg::TEMP_W-1], measured_temp}
				- {target_temp[pireg_pkg::TEMP_W-1], target_temp};
			divn_q  <= (cfg.integral_divisor == '0) ?
				pireg_pkg::TDIV_W'(1) : cfg.integral_divisor;
		end
		if (state_q == pireg_pkg::S_SUM) begin
			integ_q <= (IW+2)'(store_rd) + (IW+2)'(err_q);
			prod_q  <= mul_res;
		end
		if (state_q == pireg_pkg::S_CLAMP) begin
			integ_new_q <= clamp_v[IW-1:0];
		end
		if (state_q == pireg_pkg::S_PROD) begin
			prod_q <= mul_res;
		end
		if ((state_q == pireg_pkg::S_DIV) && div_rsp.done) begin
			drv_q <= drv_sum;
		end
		if (out_load) begin
			drive_q <= lim_v[pireg_pkg::DRIVE_W-1:0];
		end
	end

	// Output word register: set on load, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign drive_level = drive_q;

endmodule

### design/pireg_chk.sv
// ---------------------------------------------------------------------------
// pireg_chk
// Port-level checker for the regulator, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pireg_chk (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_ready,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic        [pireg_pkg::DRIVE_W-1:0] drive_level
);

	// A pending word holds until taken
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(drive_level), "output word changed or dropped while stalled")

	// Busy right after accepting a word
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready, "input ready right after acceptance")

	// A result never appears the cycle after acceptance
	`ASSERT_NEXT(a_no_early_result, clk, arst_n, in_valid && in_ready, !$rose(out_valid), "result appeared too early")

	// The block turns ready only together with a new result being loaded
	`ASSERT_SAME(a_ready_with_result, clk, arst_n, $rose(in_ready), $rose(out_valid) || (out_valid && !$stable(drive_level)) || (out_valid && $past(out_ready)), "ready without a result loaded")

endmodule

bind multichannel_pi_temperature_regulator pireg_chk u_pireg_chk (.*);

### tb/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multichannel PI temperature regulator. Every
// accepted input word is run through a behavioral copy of the regulator,
// which keeps its own integrals and register mirror. Each drive_level word
// taken from the block is checked against the oldest prediction. Phases cover
// default, extreme, inverted-limit, zero-divisor and random register settings
// under changing sender and receiver idling.
// ---------------------------------------------------------------------------
import pireg_pkg::*;

// Register mirror, per-channel integrals and the queue of predicted drives
class drive_scoreboard;
	cfg_t                      regs;
	logic signed [INTEG_W-1:0] integ_mem [NUM_CHANNELS];
	logic [DRIVE_W-1:0]        pending_drive [$];
	int                        errors;

	function new();
		regs.prop_gain        = 8'd10;
		regs.integral_divisor = 10'd10;
		regs.integral_upper   = 16'sd32767;
		regs.integral_lower   = -16'sd32768;
		regs.drive_high_limit = 10'd1000;
		regs.drive_full_on    = 10'd1000;
		regs.drive_low_limit  = 10'd0;
		regs.drive_full_off   = 10'd0;
		foreach (integ_mem[i])
			integ_mem[i] = '0;
		errors = 0;
	endfunction

	// Mirror one register write, keeping only the register's own width
	function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_PROP_GAIN:   regs.prop_gain        = data[GAIN_W-1:0];
			REG_INTEG_DIV:   regs.integral_divisor = data[TDIV_W-1:0];
			REG_INTEG_UPPER: regs.integral_upper   = data;
			REG_INTEG_LOWER: regs.integral_lower   = data;
			REG_DRIVE_HIGH:  regs.drive_high_limit = data[DRIVE_W-1:0];
			REG_DRIVE_ON:    regs.drive_full_on    = data[DRIVE_W-1:0];
			REG_DRIVE_LOW:   regs.drive_low_limit  = data[DRIVE_W-1:0];
			REG_DRIVE_OFF:   regs.drive_full_off   = data[DRIVE_W-1:0];
			default: ;
		endcase
	endfunction

	// Run one control update and queue the drive it produces
	function void note_word(logic [CHAN_W-1:0] c, logic signed [TEMP_W-1:0] m,
			logic signed [TEMP_W-1:0] t);
		longint err, dv, acc, floor_v, drv;
		bit     in_range;
		err      = longint'(m) - longint'(t);
		dv       = (regs.integral_divisor == 0) ? 1 : longint'(regs.integral_divisor);
		in_range = (int'(c) < NUM_CHANNELS);
		acc      = in_range ? longint'(integ_mem[c]) : 0;
		floor_v  = longint'(PRELOAD_SCALE) * dv;
		// Accumulate, preload on a positive error, then clamp upper first
		acc = acc + err;
		if (err > 0 && acc < floor_v)
			acc = floor_v;
		if (acc > longint'($signed(regs.integral_upper)))
			acc = longint'($signed(regs.integral_upper));
		if (acc < longint'($signed(regs.integral_lower)))
			acc = longint'($signed(regs.integral_lower));
		if (in_range)
			integ_mem[c] = acc[INTEG_W-1:0];
		// Drive with limit substitution, high test before low test
		drv = longint'(regs.prop_gain) * err + acc / dv;
		if (drv > longint'(regs.drive_high_limit))
			drv = longint'(regs.drive_full_on);
		if (drv < longint'(regs.drive_low_limit))
			drv = longint'(regs.drive_full_off);
		pending_drive.push_back(drv[DRIVE_W-1:0]);
	endfunction

	// Compare one taken result with the oldest prediction
	function void check_drive(logic [DRIVE_W-1:0] actual);
		logic [DRIVE_W-1:0] exp_drive;
		if (pending_drive.size() == 0) begin
			$error("drive_level: no word expected, actual %0d", actual);
			errors++;
		end else begin
			exp_drive = pending_drive.pop_front();
			if (actual !== exp_drive) begin
				$error("drive_level: expected %0d, actual %0d", exp_drive, actual);
				errors++;
			end
		end
	endfunction
endclass

module tb_top;
	logic                        clk           = 1'b0;
	logic                        arst_n        = 1'b0;
	logic                        cfg_we        = 1'b0;
	logic [CFG_IDX_W-1:0]        cfg_idx       = REG_PROP_GAIN;
	logic [CFG_DATA_W-1:0]       cfg_wdata     = '0;
	logic                        in_valid      = 1'b0;
	logic                        in_ready;
	logic [CHAN_W-1:0]           chan          = '0;
	logic signed [TEMP_W-1:0]    measured_temp = '0;
	logic signed [TEMP_W-1:0]    target_temp   = '0;
	logic                        out_valid;
	logic                        out_ready     = 1'b0;
	logic [DRIVE_W-1:0]          drive_level;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	drive_scoreboard sb = new();

	multichannel_pi_temperature_regulator u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.chan          (chan),
		.measured_temp (measured_temp),
		.target_temp   (target_temp),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.drive_level   (drive_level)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: stall at random with the current phase's rate
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Watch both channels; results are checked before the new word is noted
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_drive(drive_level);
			if (in_valid && in_ready)
				sb.note_word(chan, measured_temp, target_temp);
		end
	end

	// Offer one word, idling first at random, and hold it until taken
	task automatic send_word(logic [CHAN_W-1:0] c, logic signed [TEMP_W-1:0] m,
			logic signed [TEMP_W-1:0] t);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		in_valid      <= 1'b1;
		chan          <= c;
		measured_temp <= m;
		target_temp   <= t;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// Random word: mostly small errors around a plausible setpoint
	task automatic send_random_word();
		logic [CHAN_W-1:0]        c;
		logic signed [TEMP_W-1:0] m;
		logic signed [TEMP_W-1:0] t;
		int                       e;
		c = ($urandom_range(9) == 0) ? CHAN_W'(3) : CHAN_W'($urandom_range(NUM_CHANNELS - 1));
		if ($urandom_range(3) == 0) begin
			m = TEMP_W'($urandom);
			t = TEMP_W'($urandom);
		end else begin
			e = int'($urandom_range(240)) - 120;
			t = TEMP_W'(int'($urandom_range(900)) - 100);
			m = t + TEMP_W'(e);
		end
		send_word(c, m, t);
	endtask

	// Drop valid, let the last accepted word be noted, then hold off until
	// every predicted drive has been taken
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_drive.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		sb.set_reg(idx, data);
	endtask

	// Write all registers back to back while the block is idle
	task automatic load_config(int gain, int tdiv, int up, int lo, int hi, int on,
			int lw, int off);
		write_reg(REG_PROP_GAIN,   CFG_DATA_W'(gain));
		write_reg(REG_INTEG_DIV,   CFG_DATA_W'(tdiv));
		write_reg(REG_INTEG_UPPER, CFG_DATA_W'(up));
		write_reg(REG_INTEG_LOWER, CFG_DATA_W'(lo));
		write_reg(REG_DRIVE_HIGH,  CFG_DATA_W'(hi));
		write_reg(REG_DRIVE_ON,    CFG_DATA_W'(on));
		write_reg(REG_DRIVE_LOW,   CFG_DATA_W'(lw));
		write_reg(REG_DRIVE_OFF,   CFG_DATA_W'(off));
		cfg_we <= 1'b0;
	endtask

	// Random words with an occasional full drain in between
	task automatic run_random(int count);
		for (int i = 0; i < count; i++) begin
			send_random_word();
			if ($urandom_range(59) == 0)
				drain();
		end
		drain();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words at reset settings, no idling
		send_word(2'd0, 16'sd250, 16'sd200);        // positive error: preload floor
		send_word(2'd0, 16'sd260, 16'sd200);
		send_word(2'd0, 16'sd300, 16'sd200);        // drive over the high limit
		send_word(2'd0, 16'sd150, 16'sd200);
		send_word(2'd0, -16'sd400, 16'sd200);       // drive under the low limit
		send_word(2'd1, 16'sd32767, -16'sd32768);   // largest error, integral saturates
		send_word(2'd1, 16'sd32767, -16'sd32768);
		send_word(2'd1, -16'sd32768, 16'sd32767);   // most negative error
		send_word(2'd1, -16'sd32768, 16'sd32767);
		send_word(2'd2, 16'sd0, 16'sd0);
		send_word(2'd2, -16'sd32768, -16'sd32768);
		send_word(2'd2, 16'sd32767, 16'sd32767);
		send_word(2'd2, 16'sd201, 16'sd200);
		send_word(2'd2, 16'sd199, 16'sd200);
		send_word(2'd3, 16'sd250, 16'sd200);        // channel out of range
		send_word(2'd3, -16'sd32768, 16'sd32767);
		send_word(2'd3, 16'sd32767, -16'sd32768);
		send_word(2'd0, 16'sd200, 16'sd200);
		send_word(2'd1, 16'sd5, 16'sd0);
		send_word(2'd2, -16'sd21846, 16'sd21845);
		drain();

		// Extreme settings, sender idling
		load_config(255, 1023, 32767, -32768, 1000, 1000, 0, 0);
		send_idle_pct  = 61;
		recv_stall_pct = 0;
		run_random(80);

		// Zero divisor and inverted integral limits, receiver stalling
		load_config(3, 0, -100, 100, 900, 950, 50, 20);
		send_idle_pct  = 0;
		recv_stall_pct = 61;
		run_random(80);

		// Inverted drive limits, light idling on both sides
		load_config(1, 1, 20000, -20000, 200, 7, 600, 999);
		send_idle_pct  = 7;
		recv_stall_pct = 7;
		run_random(80);

		// Random settings, heavy idling on both sides
		load_config($urandom_range(255), $urandom_range(1023), int'($urandom),
			int'($urandom), $urandom_range(1000), $urandom_range(1000),
			$urandom_range(1000), $urandom_range(1000));
		send_idle_pct  = 61;
		recv_stall_pct = 61;
		run_random(80);

		// Random settings again, no idling
		load_config($urandom_range(255), $urandom_range(1023), int'($urandom),
			int'($urandom), $urandom_range(1000), $urandom_range(1000),
			$urandom_range(1000), $urandom_range(1000));
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		run_random(80);

		if (sb.errors == 0 && sb.pending_drive.size() == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("tb_top: done, errors");
		$finish;
	end

endmodule
